/* src/mdfe_pkg.sv */
// package for the marker delimited frame extractor
// marker constants, window and result types; no dependencies
package mdfe_pkg;

    localparam int MARKER_LEN = 10;
    localparam int FILL_W     = 4;
    localparam int COUNT_W    = 32;
    localparam int BYTE_W     = 8;
    localparam int OUT_DATA_W = BYTE_W + COUNT_W;

    typedef logic [0:MARKER_LEN-1][BYTE_W-1:0] win_t;

    // 05 A L X P A C S V R
    localparam win_t START_MARK = '{
        8'h05, 8'h41, 8'h4c, 8'h58, 8'h50, 8'h41, 8'h43, 8'h53, 8'h56, 8'h52
    };

    // 17 C E S T F I N I 04
    localparam win_t END_MARK = '{
        8'h17, 8'h43, 8'h45, 8'h53, 8'h54, 8'h46, 8'h49, 8'h4e, 8'h49, 8'h04
    };

    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(MARKER_LEN);

    typedef struct packed {
        logic               payload_valid;
        logic [BYTE_W-1:0]  payload_byte;
        logic               frame_end;
        logic [COUNT_W-1:0] frame_count;
    } res_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } in_word_t;

endpackage

/* src/marker_delimited_frame_extractor.sv */
// marker delimited frame extractor, top level
// one byte word per cycle unless stalled; a word passes input and result registers
// throughput one word per cycle unless stalled, set by shift and compares in one stage
// input register and result register together hold two words under stall
// asynchronous active-low reset clears window, fill, frame flag, frame count and valids
// depends on mdfe_pkg, mdfe_in_stage, mdfe_core, mdfe_out_stage
module marker_delimited_frame_extractor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // payload_byte, frame_count
    output logic [0:0]  m_axis_tuser,   // payload_valid
    output logic        m_axis_tlast    // frame_end
);
    import mdfe_pkg::*;

    in_word_t word;
    logic     advance;
    logic     can_take;
    logic     res_valid;
    res_t     res;

    assign advance = word.valid && can_take;

    mdfe_in_stage u_in (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .s_data  (s_axis_tdata),
        .advance (advance),
        .word    (word)
    );

    mdfe_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .word      (word),
        .advance   (advance),
        .res_valid (res_valid),
        .res       (res)
    );

    mdfe_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .can_take  (can_take),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_data    (m_axis_tdata),
        .m_user    (m_axis_tuser[0]),
        .m_last    (m_axis_tlast)
    );

endmodule

/* src/mdfe_in_stage.sv */
// input register of the frame extractor
// depends on mdfe_pkg
module mdfe_in_stage (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [7:0]              s_data,
    input  logic                    advance,
    output mdfe_pkg::in_word_t      word
);
    import mdfe_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_ready && s_valid)
        begin
            data_reg <= s_data;
        end
    end

    assign word.valid = valid_reg;
    assign word.data  = data_reg;

endmodule

/* src/mdfe_core.sv */
// window, marker compares, frame state and frame counter
// depends on mdfe_pkg
module mdfe_core (
    input  logic               clk,
    input  logic               rst_n,
    input  mdfe_pkg::in_word_t word,
    input  logic               advance,
    output logic               res_valid,
    output mdfe_pkg::res_t     res
);
    import mdfe_pkg::*;

    win_t               window_reg;
    win_t               window_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic               in_frame_reg;
    logic               in_frame_next;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] total_next;

    win_t              shifted;
    logic              was_full;
    logic              full_after;
    logic              start_hit;
    logic              end_hit;
    logic [BYTE_W-1:0] leaving;

    always_comb
    begin
        for (int i = 0; i < MARKER_LEN - 1; i++)
        begin
            shifted[i] = window_reg[i+1];
        end
        shifted[MARKER_LEN-1] = word.data;
    end

    assign leaving    = window_reg[0];
    assign was_full   = (fill_reg == FILL_FULL);
    assign full_after = was_full || (fill_reg == FILL_FULL - 1'b1);
    assign start_hit  = full_after && (shifted == START_MARK);
    assign end_hit    = full_after && (shifted == END_MARK);

    always_comb
    begin
        window_next   = window_reg;
        fill_next     = fill_reg;
        in_frame_next = in_frame_reg;
        total_next    = total_reg;
        res_valid     = 1'b0;
        if (advance)
        begin
            window_next = shifted;
            fill_next   = was_full ? fill_reg : fill_reg + 1'b1;
            if (!in_frame_reg)
            begin
                if (start_hit)
                begin
                    in_frame_next = 1'b1;
                    fill_next     = '0;
                end
            end
            else
            begin
                res_valid = was_full || end_hit;
                if (end_hit)
                begin
                    in_frame_next = 1'b0;
                    fill_next     = '0;
                    total_next    = total_reg + 1'b1;
                end
            end
        end
    end

    assign res.payload_valid = was_full;
    assign res.payload_byte  = was_full ? leaving : '0;
    assign res.frame_end     = end_hit;
    assign res.frame_count   = total_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg   <= '0;
            fill_reg     <= '0;
            in_frame_reg <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            window_reg   <= window_next;
            fill_reg     <= fill_next;
            in_frame_reg <= in_frame_next;
            total_reg    <= total_next;
        end
    end

endmodule

/* src/mdfe_out_stage.sv */
// result register driving the master side of the stream
// depends on mdfe_pkg
module mdfe_out_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         res_valid,
    input  mdfe_pkg::res_t               res,
    output logic                         can_take,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [mdfe_pkg::OUT_DATA_W-1:0] m_data,
    output logic                         m_user,
    output logic                         m_last
);
    import mdfe_pkg::*;

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    assign can_take   = !valid_reg || m_ready;
    assign valid_next = can_take ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_take && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = {res_reg.frame_count, res_reg.payload_byte};
    assign m_user  = res_reg.payload_valid;
    assign m_last  = res_reg.frame_end;

endmodule

/* tb/marker_delimited_frame_extractor_tb.sv */
// testbench for marker_delimited_frame_extractor: byte stream in, payload and frame-end words out
// predicts each output word from its own copy of the window state and checks every field
// depends only on the rtl top level; stands alone, no files read
module marker_delimited_frame_extractor_tb;

    localparam int MARK_LEN     = 10;
    localparam int MAX_GAP      = 13;
    localparam int LONG_HOLD    = 200;
    localparam int SETTLE_TAIL  = 8;
    localparam int RANDOM_ITEMS = 1500;

    // oldest byte in the top bits
    localparam logic [8*MARK_LEN-1:0] START_SEQ = 80'h05_41_4c_58_50_41_43_53_56_52;
    localparam logic [8*MARK_LEN-1:0] END_SEQ   = 80'h17_43_45_53_54_46_49_4e_49_04;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        frame_end;
        logic [31:0] frame_count;
    } out_word_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;    // in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // payload_byte, frame_count
    logic [0:0]  m_axis_tuser;    // payload_valid
    logic        m_axis_tlast;    // frame_end

    // predictor state
    logic [8*MARK_LEN-1:0] win_bits = '0;
    int                    win_fill = 0;
    bit                    frame_open = 1'b0;
    logic [31:0]           frames_closed = '0;
    out_word_t             deframed_q[$];

    bit src_idle_on   = 1'b0;
    bit sink_idle_on  = 1'b0;
    bit sink_hold_req = 1'b0;

    int fail_count    = 0;
    int live_items    = 0;
    int bytes_sent    = 0;
    int payload_words = 0;
    int end_words     = 0;
    int joint_words   = 0;

    marker_delimited_frame_extractor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // returns 1 when the byte mattered, i.e. not a byte dropped outside a frame
    function automatic bit deframe_byte(input logic [7:0] b);
        logic      was_full;
        logic [7:0] leaving;
        out_word_t w;
        was_full = (win_fill == MARK_LEN);
        leaving  = win_bits[8*MARK_LEN-1 -: 8];
        win_bits = {win_bits[8*MARK_LEN-9:0], b};
        if (!was_full)
            win_fill++;
        if (!frame_open)
        begin
            if (win_fill == MARK_LEN && win_bits == START_SEQ)
            begin
                frame_open = 1'b1;
                win_fill   = 0;
                return 1'b1;
            end
            return 1'b0;
        end
        w.payload_valid = was_full;
        w.payload_byte  = was_full ? leaving : 8'h00;
        w.frame_end     = 1'b0;
        if (win_fill == MARK_LEN && win_bits == END_SEQ)
        begin
            w.frame_end   = 1'b1;
            frame_open    = 1'b0;
            win_fill      = 0;
            frames_closed = frames_closed + 32'd1;
        end
        w.frame_count = frames_closed;
        if (w.payload_valid || w.frame_end)
            deframed_q.push_back(w);
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        bytes_sent++;
        if (deframe_byte(b))
            live_items++;
    endtask

    // first len bytes of a marker
    task automatic send_marker(input logic [8*MARK_LEN-1:0] seq, input int len);
        for (int i = 0; i < len; i++)
            send_byte(seq[8*MARK_LEN-1-8*i -: 8]);
    endtask

    // sender pause until every predicted word is out
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (deframed_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TAIL) @(posedge clk);
    endtask

    // noise at the byte extremes, then a frame whose last payload byte leaves with the end marker
    task automatic test_directed_frame();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_byte(8'h00);
        send_byte(8'hff);
        send_marker(START_SEQ, MARK_LEN);
        send_byte(8'h00);
        send_byte(8'hff);
        send_marker(END_SEQ, MARK_LEN);
        wait_for_results();
    endtask

    // receiver holds off while the sender keeps offering bytes
    task automatic test_output_stall();
        src_idle_on   = 1'b0;
        sink_idle_on  = 1'b0;
        sink_hold_req = 1'b1;
        send_marker(START_SEQ, MARK_LEN);
        repeat (60) send_byte(8'($urandom_range(0, 255)));
        send_marker(END_SEQ, MARK_LEN);
        wait_for_results();
    endtask

    task automatic send_random_frame();
        int n;
        int pick;
        n = $urandom_range(0, 4);
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        pick = $urandom_range(0, 9);
        if (pick == 0)
            send_marker(START_SEQ, $urandom_range(1, MARK_LEN - 1));
        else if (pick == 1)
            send_marker(END_SEQ, MARK_LEN);
        send_marker(START_SEQ, MARK_LEN);
        pick = $urandom_range(0, 19);
        n = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(40, 60) : $urandom_range(1, 24);
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 29);
            if (pick == 0)
                send_marker(START_SEQ, MARK_LEN);
            else if (pick == 1)
                send_marker(END_SEQ, $urandom_range(1, MARK_LEN - 1));
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        // now and then a frame is left open and runs into the next one
        if ($urandom_range(0, 19) != 0)
            send_marker(END_SEQ, MARK_LEN);
    endtask

    task automatic test_random_stream();
        while (bytes_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                src_idle_on  = 1'($urandom_range(0, 1));
                sink_idle_on = 1'($urandom_range(0, 1));
            end
            send_random_frame();
            if ($urandom_range(0, 15) == 0)
                wait_for_results();
        end
        wait_for_results();
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 8'h00;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_frame();
        test_output_stall();
        test_random_stream();
        $display("covered %0d bytes in (%0d inside frames), %0d frames closed, %0d payload words",
                 bytes_sent, live_items, end_words, payload_words);
        $display("%0d words carried payload and frame end together", joint_words);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // receiver side
    initial
    begin
        int gap;
        m_axis_tready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (sink_hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                sink_hold_req = 1'b0;
            end
            gap = sink_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            if (gap != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : check_words
        out_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (deframed_q.size() == 0)
            begin
                $error("unexpected word: tdata %h tuser %b tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                fail_count++;
            end
            else
            begin
                want = deframed_q.pop_front();
                if (m_axis_tuser[0] !== want.payload_valid)
                begin
                    $error("payload_valid expected %0d got %0d", want.payload_valid,
                           m_axis_tuser[0]);
                    fail_count++;
                end
                if (m_axis_tdata[7:0] !== want.payload_byte)
                begin
                    $error("payload_byte expected %h got %h", want.payload_byte,
                           m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tlast !== want.frame_end)
                begin
                    $error("frame_end expected %0d got %0d", want.frame_end, m_axis_tlast);
                    fail_count++;
                end
                if (m_axis_tdata[39:8] !== want.frame_count)
                begin
                    $error("frame_count expected %0d got %0d", want.frame_count,
                           m_axis_tdata[39:8]);
                    fail_count++;
                end
                if (want.payload_valid)
                    payload_words++;
                if (want.frame_end)
                    end_words++;
                if (want.payload_valid && want.frame_end)
                    joint_words++;
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("timeout with %0d words still expected", deframed_q.size());
        $display("FAILURE");
        $finish;
    end

endmodule
